// File: src/tsse_pkg.sv
// Package for the two-stream sequence-equal unit.
// Holds the command type and command codes. No dependencies.
package tsse_pkg;

    typedef logic [2:0] command_t;

    localparam command_t CMD_FIRST_ITEM   = 3'd0;
    localparam command_t CMD_SECOND_ITEM  = 3'd1;
    localparam command_t CMD_FIRST_ENDED  = 3'd2;
    localparam command_t CMD_SECOND_ENDED = 3'd3;
    localparam command_t CMD_RESTART      = 3'd4;

endpackage

// File: src/tsse_if.sv
// Valid/ready channel interfaces for the two-stream sequence-equal unit.
// Depends on tsse_pkg for the command type.
interface tsse_item_if
    import tsse_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
);
    logic                   valid;
    logic                   ready;
    command_t               command;
    logic [VALUE_WIDTH-1:0] item_value;

    modport source (output valid, output command, output item_value, input ready);
    modport sink   (input valid, input command, input item_value, output ready);
endinterface

interface tsse_verdict_if;
    logic valid;
    logic ready;
    logic sequences_equal;
    logic fault;

    modport source (output valid, output sequences_equal, output fault, input ready);
    modport sink   (input valid, input sequences_equal, input fault, output ready);
endinterface

// File: src/two_stream_sequence_equal_unit.sv
// Two-stream sequence-equal unit: top level, skew buffer memory and control.
// Depends on tsse_pkg and the channel interfaces in tsse_if.sv.
//
//   channel   modport  dir  payload                       transfer when
//   items     sink     in   command, item_value           valid && ready
//   verdicts  source   out  sequences_equal, fault        valid && ready
//
// One item per cycle, sustained while items.ready stays high. A verdict reaches
// verdicts from the item that causes it through the compare stage, fed by the
// registered skew buffer read, and then through the output register.
// Reset (rst_n low, async) empties the buffer and clears the end and verdict
// flags; buffer contents are not cleared, only entries counted as held are read.
// items.ready drops only while a verdict waits in the compare stage and the
// output register is still full and not being taken.
module two_stream_sequence_equal_unit
    import tsse_pkg::*;
#(
    parameter int BUFFER_DEPTH = 16,
    parameter int VALUE_WIDTH  = 32
)(
    input  logic        clk,
    input  logic        rst_n,
    tsse_item_if.sink   items,
    tsse_verdict_if.source verdicts
);

    localparam int PTR_W = $clog2(BUFFER_DEPTH);
    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUFFER_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(BUFFER_DEPTH);

    // skew buffer
    logic [VALUE_WIDTH-1:0] mem [BUFFER_DEPTH];
    logic [VALUE_WIDTH-1:0] head_data_reg;
    logic                   mem_we;
    logic                   mem_re;

    // buffer control
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             side_reg, side_next;
    logic             first_ended_reg, first_ended_next;
    logic             second_ended_reg, second_ended_next;
    logic             verdict_reg, verdict_next;

    // compare stage: either a pop to compare or a verdict already known
    logic                   cmp_valid_reg, cmp_valid_next;
    logic                   cmp_fixed_reg, cmp_fixed_next;
    logic                   cmp_eq_reg, cmp_eq_next;
    logic                   cmp_fault_reg, cmp_fault_next;
    logic [VALUE_WIDTH-1:0] cmp_value_reg, cmp_value_next;

    // output register
    logic out_valid_reg, out_valid_next;
    logic out_eq_reg, out_eq_next;
    logic out_fault_reg, out_fault_next;

    logic cmp_verdict;
    logic cmp_block;
    logic accept;
    logic side;
    logic other_ended;
    logic own_held;

    // A verdict leaves the compare stage on a mismatch or a precomputed result.
    assign cmp_verdict = cmp_valid_reg &&
                         (cmp_fixed_reg || (head_data_reg != cmp_value_reg));
    assign cmp_block   = cmp_verdict && out_valid_reg && !verdicts.ready;
    assign items.ready = !cmp_block;
    assign accept      = items.valid && !cmp_block;

    assign verdicts.valid           = out_valid_reg;
    assign verdicts.sequences_equal = out_eq_reg;
    assign verdicts.fault           = out_fault_reg;

    always_comb
    begin
        rptr_next         = rptr_reg;
        wptr_next         = wptr_reg;
        count_next        = count_reg;
        side_next         = side_reg;
        first_ended_next  = first_ended_reg;
        second_ended_next = second_ended_reg;
        verdict_next      = verdict_reg | (cmp_verdict && !cmp_block);
        mem_we            = 1'b0;
        mem_re            = 1'b0;
        side              = 1'b0;
        other_ended       = 1'b0;
        own_held          = 1'b0;

        cmp_valid_next = cmp_block ? cmp_valid_reg : 1'b0;
        cmp_fixed_next = cmp_fixed_reg;
        cmp_eq_next    = cmp_eq_reg;
        cmp_fault_next = cmp_fault_reg;
        cmp_value_next = cmp_value_reg;

        out_valid_next = out_valid_reg && !verdicts.ready;
        out_eq_next    = out_eq_reg;
        out_fault_next = out_fault_reg;
        if (cmp_verdict && !cmp_block)
        begin
            out_valid_next = 1'b1;
            out_eq_next    = cmp_fixed_reg & cmp_eq_reg;
            out_fault_next = cmp_fixed_reg & cmp_fault_reg;
        end

        if (accept)
        begin
            if (items.command == CMD_RESTART)
            begin
                rptr_next         = '0;
                wptr_next         = '0;
                count_next        = '0;
                side_next         = 1'b0;
                first_ended_next  = 1'b0;
                second_ended_next = 1'b0;
                verdict_next      = 1'b0;
            end
            else if (!(verdict_reg || cmp_verdict))
            begin
                case (items.command)
                    CMD_FIRST_ITEM, CMD_SECOND_ITEM:
                    begin
                        side        = (items.command == CMD_SECOND_ITEM);
                        other_ended = side ? first_ended_reg : second_ended_reg;
                        if (count_reg != '0 && side_reg != side)
                        begin
                            // other stream holds items: pop the oldest, compare next cycle
                            mem_re         = 1'b1;
                            rptr_next      = (rptr_reg == PTR_LAST) ? '0 : rptr_reg + 1'b1;
                            count_next     = count_reg - 1'b1;
                            cmp_valid_next = 1'b1;
                            cmp_fixed_next = 1'b0;
                            cmp_value_next = items.item_value;
                        end
                        else if (other_ended)
                        begin
                            cmp_valid_next = 1'b1;
                            cmp_fixed_next = 1'b1;
                            cmp_eq_next    = 1'b0;
                            cmp_fault_next = 1'b0;
                        end
                        else if (count_reg == CNT_FULL)
                        begin
                            // overflow ends the check with a fault
                            cmp_valid_next = 1'b1;
                            cmp_fixed_next = 1'b1;
                            cmp_eq_next    = 1'b0;
                            cmp_fault_next = 1'b1;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            wptr_next  = (wptr_reg == PTR_LAST) ? '0 : wptr_reg + 1'b1;
                            count_next = count_reg + 1'b1;
                            side_next  = side;
                        end
                    end
                    CMD_FIRST_ENDED, CMD_SECOND_ENDED:
                    begin
                        side = (items.command == CMD_SECOND_ENDED);
                        if (side)
                        begin
                            second_ended_next = 1'b1;
                            other_ended       = first_ended_reg;
                        end
                        else
                        begin
                            first_ended_next = 1'b1;
                            other_ended      = second_ended_reg;
                        end
                        own_held = (count_reg != '0) && (side_reg == side);
                        if (!own_held)
                        begin
                            if (count_reg != '0)
                            begin
                                // ended while the other stream still has items
                                cmp_valid_next = 1'b1;
                                cmp_fixed_next = 1'b1;
                                cmp_eq_next    = 1'b0;
                                cmp_fault_next = 1'b0;
                            end
                            else if (other_ended)
                            begin
                                cmp_valid_next = 1'b1;
                                cmp_fixed_next = 1'b1;
                                cmp_eq_next    = 1'b1;
                                cmp_fault_next = 1'b0;
                            end
                        end
                    end
                    default:
                    begin
                        // unused codes are ignored
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rptr_reg         <= '0;
            wptr_reg         <= '0;
            count_reg        <= '0;
            side_reg         <= 1'b0;
            first_ended_reg  <= 1'b0;
            second_ended_reg <= 1'b0;
            verdict_reg      <= 1'b0;
            cmp_valid_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            rptr_reg         <= rptr_next;
            wptr_reg         <= wptr_next;
            count_reg        <= count_next;
            side_reg         <= side_next;
            first_ended_reg  <= first_ended_next;
            second_ended_reg <= second_ended_next;
            verdict_reg      <= verdict_next;
            cmp_valid_reg    <= cmp_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        cmp_fixed_reg <= cmp_fixed_next;
        cmp_eq_reg    <= cmp_eq_next;
        cmp_fault_reg <= cmp_fault_next;
        cmp_value_reg <= cmp_value_next;
        out_eq_reg    <= out_eq_next;
        out_fault_reg <= out_fault_next;
    end

    // skew buffer: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wptr_reg] <= items.item_value;
        end
        if (mem_re)
        begin
            head_data_reg <= mem[rptr_reg];
        end
    end

endmodule

// File: tb/two_stream_sequence_equal_unit_tb.sv
// Self-checking testbench for two_stream_sequence_equal_unit.
// Depends on tsse_pkg, tsse_if.sv (tsse_item_if, tsse_verdict_if) and the unit itself.
// Directed and random command streams are checked against a built-in verdict predictor.
module two_stream_sequence_equal_unit_tb;
    import tsse_pkg::*;

    localparam int BUFFER_DEPTH     = 16;
    localparam int VALUE_WIDTH      = 32;
    localparam int PTR_WIDTH        = $clog2(BUFFER_DEPTH);
    localparam int RESET_CYCLES     = 9;
    localparam int RANDOM_ITEMS     = 1770;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES    = 10;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int CMD_SLOTS        = 4096;
    localparam int VERDICT_SLOTS    = 64;
    localparam int SEQ_SLOTS        = BUFFER_DEPTH + 4;

    // Command codes the unit must ignore.
    localparam command_t CMD_UNUSED_FIRST = 3'd5;
    localparam command_t CMD_UNUSED_MID   = 3'd6;
    localparam command_t CMD_UNUSED_LAST  = 3'd7;

    typedef struct packed {
        command_t               command;
        logic [VALUE_WIDTH-1:0] item_value;
    } stream_cmd_t;

    typedef struct packed {
        logic sequences_equal;
        logic fault;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n;

    tsse_item_if #(.VALUE_WIDTH(VALUE_WIDTH)) item_bus ();
    tsse_verdict_if verdict_bus ();

    two_stream_sequence_equal_unit #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .VALUE_WIDTH  (VALUE_WIDTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .items    (item_bus),
        .verdicts (verdict_bus)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stimulus waiting for the driver, and verdicts the predictor says are due.
    // Both are rings indexed by running write and read counts.
    stream_cmd_t pending_cmds [CMD_SLOTS];
    int          cmd_wr = 0;
    int          cmd_rd = 0;
    verdict_t    due_verdicts [VERDICT_SLOTS];
    int          due_wr = 0;
    int          due_rd = 0;

    int  mismatch_count = 0;
    int  useful_items   = 0;
    int  send_idle_pct  = 0;
    int  recv_idle_pct  = 0;
    bit  hold_armed     = 1'b0;
    int  hold_cycles    = 0;
    bit  item_fired     = 1'b0;
    int  cycle_count    = 0;

    // ------------------------------------------------------------------
    // Verdict predictor: its own copy of the comparison state.
    // ------------------------------------------------------------------
    logic [VALUE_WIDTH-1:0] held_values [BUFFER_DEPTH];
    logic [PTR_WIDTH-1:0]   head_idx;
    logic [PTR_WIDTH-1:0]   tail_idx;
    logic [PTR_WIDTH:0]     held_total;
    logic                   held_owner;     // 0 first stream, 1 second stream
    logic                   first_done;
    logic                   second_done;
    logic                   decided;

    // Held values are left alone; only counted entries are ever read.
    task automatic restart_compare();
        head_idx    = '0;
        tail_idx    = '0;
        held_total  = '0;
        held_owner  = 1'b0;
        first_done  = 1'b0;
        second_done = 1'b0;
        decided     = 1'b0;
    endtask

    task automatic predict_verdict(input stream_cmd_t cmd);
        verdict_t               v;
        logic                   side;
        logic                   other_done;
        logic                   gives;
        logic [VALUE_WIDTH-1:0] popped;
        v     = '0;
        gives = 1'b0;
        case (cmd.command)
            CMD_RESTART:
            begin
                restart_compare();
            end
            CMD_FIRST_ITEM, CMD_SECOND_ITEM:
            begin
                if (!decided)
                begin
                    side       = (cmd.command == CMD_SECOND_ITEM);
                    other_done = side ? first_done : second_done;
                    if (held_total != 0 && held_owner != side)
                    begin
                        // Other stream is ahead: pop its oldest value and compare.
                        popped     = held_values[head_idx];
                        head_idx   = head_idx + 1'b1;
                        held_total = held_total - 1'b1;
                        if (popped != cmd.item_value)
                            gives = 1'b1;
                    end
                    else if (other_done)
                        gives = 1'b1;           // nothing left on the other side
                    else if (held_total == BUFFER_DEPTH)
                    begin
                        gives   = 1'b1;         // skew buffer overflow
                        v.fault = 1'b1;
                    end
                    else
                    begin
                        held_values[tail_idx] = cmd.item_value;
                        tail_idx   = tail_idx + 1'b1;
                        held_total = held_total + 1'b1;
                        held_owner = side;
                    end
                end
            end
            CMD_FIRST_ENDED, CMD_SECOND_ENDED:
            begin
                if (!decided)
                begin
                    side = (cmd.command == CMD_SECOND_ENDED);
                    if (side)
                        second_done = 1'b1;
                    else
                        first_done = 1'b1;
                    other_done = side ? first_done : second_done;
                    if (held_total != 0 && held_owner == side)
                        gives = 1'b0;           // own values still waiting for a match
                    else if (held_total != 0)
                        gives = 1'b1;           // other side left unmatched values
                    else if (other_done)
                    begin
                        gives             = 1'b1;
                        v.sequences_equal = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (gives)
        begin
            decided = 1'b1;
            due_verdicts[due_wr % VERDICT_SLOTS] = v;
            due_wr++;
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("[%0d] verdict check failed: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    task automatic queue_cmd(input stream_cmd_t c);
        pending_cmds[cmd_wr % CMD_SLOTS] = c;
        cmd_wr++;
    endtask

    task automatic push_cmd(input command_t command, input logic [VALUE_WIDTH-1:0] value);
        stream_cmd_t c;
        c.command    = command;
        c.item_value = value;
        queue_cmd(c);
        useful_items++;
    endtask

    // Mostly random words, with corner patterns mixed in.
    function automatic logic [VALUE_WIDTH-1:0] pick_value();
        int pick;
        pick = $urandom_range(19, 0);
        if (pick < 14)
            return $urandom;
        else if (pick < 16)
            return '0;
        else if (pick < 18)
            return '1;
        else
            return VALUE_WIDTH'(1) << $urandom_range(VALUE_WIDTH - 1, 0);
    endfunction

    // One compare run: restart, two interleaved streams, end marks.
    // Mostly equal streams, with mismatches, length skew, early ends,
    // overflow bursts and scattered noise commands.
    task automatic add_sequence();
        logic [VALUE_WIDTH-1:0] first_vals [SEQ_SLOTS];
        logic [VALUE_WIDTH-1:0] second_vals [SEQ_SLOTS];
        int                     first_len;
        int                     second_len;
        stream_cmd_t            noise;
        int                     kind;
        int                     len;
        int                     lead_cap;
        int                     fi;
        int                     si;
        int                     k;
        bit                     first_end_sent;
        bit                     second_end_sent;
        bit                     burst;
        bit                     burst_second;
        bit                     early_end;
        bit                     take_second;

        kind         = $urandom_range(19, 0);
        lead_cap     = $urandom_range(BUFFER_DEPTH, 1);
        burst        = 1'b0;
        burst_second = $urandom_range(1, 0);
        early_end    = (kind == 18);
        if (kind == 17)
            len = $urandom_range(BUFFER_DEPTH + 3, BUFFER_DEPTH + 1);
        else if (kind == 19)
            len = $urandom_range(BUFFER_DEPTH, 10);
        else
            len = $urandom_range(8, 0);
        for (k = 0; k < len; k++)
            first_vals[k] = pick_value();
        first_len   = len;
        second_vals = first_vals;
        second_len  = len;
        case (kind)
            12, 13, 14:
            begin
                if (len != 0)
                begin
                    k = $urandom_range(len - 1, 0);
                    second_vals[k] = second_vals[k]
                        ^ (VALUE_WIDTH'(1) << $urandom_range(VALUE_WIDTH - 1, 0));
                end
            end
            15:
            begin
                if (len != 0)
                    first_len = len - 1;
            end
            16:
            begin
                second_vals[second_len] = pick_value();
                second_len++;
            end
            17, 19:
            begin
                burst = 1'b1;   // one side runs all the way ahead first
            end
            default:
            begin
            end
        endcase

        push_cmd(CMD_RESTART, pick_value());
        fi              = 0;
        si              = 0;
        first_end_sent  = 1'b0;
        second_end_sent = 1'b0;
        while (!(first_end_sent && second_end_sent))
        begin
            if (burst && (burst_second ? si < second_len : fi < first_len))
                take_second = burst_second;
            else
            begin
                take_second = $urandom_range(1, 0);
                if (!second_end_sent && fi - si >= lead_cap)
                    take_second = 1'b1;
                else if (!first_end_sent && si - fi >= lead_cap)
                    take_second = 1'b0;
            end
            if (take_second && second_end_sent)
                take_second = 1'b0;
            if (!take_second && first_end_sent)
                take_second = 1'b1;

            // Early end marks leave the stream open, so later items of the
            // same stream and a repeated end mark follow.
            if (early_end && $urandom_range(5, 0) == 0)
                push_cmd(take_second ? CMD_SECOND_ENDED : CMD_FIRST_ENDED, pick_value());
            else if (!take_second)
            begin
                if (fi < first_len)
                begin
                    push_cmd(CMD_FIRST_ITEM, first_vals[fi]);
                    fi++;
                end
                else
                begin
                    push_cmd(CMD_FIRST_ENDED, pick_value());
                    first_end_sent = 1'b1;
                end
            end
            else
            begin
                if (si < second_len)
                begin
                    push_cmd(CMD_SECOND_ITEM, second_vals[si]);
                    si++;
                end
                else
                begin
                    push_cmd(CMD_SECOND_ENDED, pick_value());
                    second_end_sent = 1'b1;
                end
            end

            if ($urandom_range(29, 0) == 0)
            begin
                noise.command    = command_t'($urandom_range(CMD_UNUSED_LAST, CMD_FIRST_ITEM));
                noise.item_value = $urandom;
                queue_cmd(noise);
            end
        end
    endtask

    // Sender pause: nothing left to send and every due verdict received.
    task automatic wait_drained();
        while (cmd_wr != cmd_rd || item_bus.valid || due_wr != due_rd)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Item driver: changes inputs at the falling edge only.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_items
        stream_cmd_t next_cmd;
        if (!rst_n)
            item_bus.valid <= 1'b0;
        else if (!item_bus.valid || item_fired)
        begin
            // Previous transfer done (or bus idle): maybe offer the next command.
            if (cmd_wr != cmd_rd && $urandom_range(99, 0) >= send_idle_pct)
            begin
                next_cmd = pending_cmds[cmd_rd % CMD_SLOTS];
                cmd_rd++;
                item_bus.valid      <= 1'b1;
                item_bus.command    <= next_cmd.command;
                item_bus.item_value <= next_cmd.item_value;
            end
            else
                item_bus.valid <= 1'b0;
        end
    end

    // Verdict receiver: random stalls plus one long hold-off, counted here.
    always @(negedge clk)
    begin : drive_ready
        if (!rst_n)
            verdict_bus.ready <= 1'b0;
        else if (hold_armed && hold_cycles < LONG_HOLD_CYCLES)
        begin
            verdict_bus.ready <= 1'b0;
            hold_cycles++;
        end
        else
            verdict_bus.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: samples both channels at the rising edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_channels
        verdict_t seen;
        verdict_t want;
        stream_cmd_t taken;
        item_fired = rst_n && item_bus.valid && item_bus.ready;
        if (rst_n && verdict_bus.valid && verdict_bus.ready)
        begin
            seen.sequences_equal = verdict_bus.sequences_equal;
            seen.fault           = verdict_bus.fault;
            if (due_wr == due_rd)
                report_mismatch($sformatf("unexpected verdict equal=%b fault=%b",
                                          seen.sequences_equal, seen.fault));
            else
            begin
                want = due_verdicts[due_rd % VERDICT_SLOTS];
                due_rd++;
                if (seen.sequences_equal !== want.sequences_equal)
                    report_mismatch($sformatf("sequences_equal %b, predicted %b",
                                              seen.sequences_equal, want.sequences_equal));
                if (seen.fault !== want.fault)
                    report_mismatch($sformatf("fault %b, predicted %b",
                                              seen.fault, want.fault));
            end
        end
        if (item_fired)
        begin
            taken.command    = item_bus.command;
            taken.item_value = item_bus.item_value;
            predict_verdict(taken);
        end
    end

    // Watchdog.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : run_test
        int phase;
        item_bus.valid      = 1'b0;
        item_bus.command    = CMD_RESTART;
        item_bus.item_value = '0;
        verdict_bus.ready   = 1'b0;
        rst_n               = 1'b0;
        restart_compare();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 15;
        recv_idle_pct = 57;

        // Directed: a mismatch on extreme values.
        push_cmd(CMD_RESTART, '0);
        push_cmd(CMD_FIRST_ITEM, '0);
        push_cmd(CMD_SECOND_ITEM, '1);
        // Item after own stream ended, repeated end mark, then a true verdict.
        push_cmd(CMD_RESTART, '1);
        push_cmd(CMD_FIRST_ENDED, '0);
        push_cmd(CMD_FIRST_ITEM, 32'hAAAA_5555);
        push_cmd(CMD_FIRST_ENDED, '1);
        push_cmd(CMD_SECOND_ITEM, 32'hAAAA_5555);
        push_cmd(CMD_SECOND_ENDED, '0);
        // Ignored after the verdict: item and unused codes.
        push_cmd(CMD_FIRST_ITEM, 32'h5555_AAAA);
        push_cmd(CMD_UNUSED_MID, '1);
        push_cmd(CMD_UNUSED_FIRST, '0);
        // Overflow: second stream runs one past the buffer depth.
        push_cmd(CMD_RESTART, '0);
        repeat (BUFFER_DEPTH + 1) push_cmd(CMD_SECOND_ITEM, pick_value());
        wait_drained();

        // Random: three idle profiles, each followed by a sender pause.
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 15;
                    recv_idle_pct = 57;
                end
                1:
                begin
                    send_idle_pct = 57;
                    recv_idle_pct = 15;
                    hold_armed    = 1'b1;   // long receiver hold-off starts now
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            useful_items = 0;
            while (useful_items < RANDOM_ITEMS / 3)
                add_sequence();
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: files.f
src/tsse_pkg.sv
src/tsse_if.sv
src/two_stream_sequence_equal_unit.sv
tb/two_stream_sequence_equal_unit_tb.sv
